### design/line_edit_buffer_defines.svh
// Assertion macros used by the checker file of the line edit buffer.
`ifndef LINE_EDIT_BUFFER_DEFINES_SVH
`define LINE_EDIT_BUFFER_DEFINES_SVH

// An implication whose consequent is checked in the cycle after the antecedent.
`define LEB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line edit buffer: next-cycle check failed");

// A condition that holds at every clock edge outside reset.
`define LEB_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("line edit buffer: invariant check failed");

`endif

### design/leb_pkg.sv
package leb_pkg;

   // Line store geometry.
   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int COUNT_W = $clog2(LINE_DEPTH + 1);

   // Highest usable flush limit: a run must fit in the store and in 63 results.
   localparam int TOP_LIMIT = (LINE_DEPTH - 2 < 61) ? LINE_DEPTH - 2 : 61;

   // Character codes.
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Register file.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [7:0] ERASE_RESET = 8'd127;
   localparam logic [7:0] KILL_RESET = 8'd21;
   localparam logic [7:0] WERASE_RESET = 8'd23;
   localparam logic CR_ONLY_RESET = 1'b0;
   localparam logic [5:0] LIMIT_RESET = 6'd61;

   typedef enum logic [2:0] {
      REG_ERASE = 3'd0,
      REG_KILL = 3'd1,
      REG_WERASE = 3'd2,
      REG_CR_ONLY = 3'd3,
      REG_LIMIT = 3'd4
   } reg_index_type;

   // Datapath operations of one control word.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_STORE_IN,
      OP_STORE_CR,
      OP_STORE_LF,
      OP_DEC,
      OP_CLEAR,
      OP_READ_PTR,
      OP_READ_LAST,
      OP_LOAD_OUT
   } op_type;

   // Jump conditions of one control word.
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_IS_ERASE,
      COND_IS_KILL,
      COND_IS_WERASE,
      COND_IS_LF,
      COND_LE_LIMIT,
      COND_OUT_BUSY,
      COND_MORE,
      COND_CR_ONLY,
      COND_COUNT_ZERO,
      COND_RD_SPACE
   } cond_type;

   // Program steps.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DEC_ERASE = 5'd1;
   localparam logic [STEP_W-1:0] STEP_DEC_KILL = 5'd2;
   localparam logic [STEP_W-1:0] STEP_DEC_WERASE = 5'd3;
   localparam logic [STEP_W-1:0] STEP_DEC_LF = 5'd4;
   localparam logic [STEP_W-1:0] STEP_STORE = 5'd5;
   localparam logic [STEP_W-1:0] STEP_LIMIT = 5'd6;
   localparam logic [STEP_W-1:0] STEP_FL_READ = 5'd7;
   localparam logic [STEP_W-1:0] STEP_FL_WAIT = 5'd8;
   localparam logic [STEP_W-1:0] STEP_FL_LOAD = 5'd9;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd10;
   localparam logic [STEP_W-1:0] STEP_NL_CR = 5'd11;
   localparam logic [STEP_W-1:0] STEP_NL_MODE = 5'd12;
   localparam logic [STEP_W-1:0] STEP_NL_LF = 5'd13;
   localparam logic [STEP_W-1:0] STEP_ERASE = 5'd14;
   localparam logic [STEP_W-1:0] STEP_WE_TEST = 5'd15;
   localparam logic [STEP_W-1:0] STEP_WE_READ = 5'd16;
   localparam logic [STEP_W-1:0] STEP_WE_CHECK = 5'd17;
   localparam logic [STEP_W-1:0] STEP_WE_DROP = 5'd18;

   typedef struct packed {
      op_type op;
      cond_type cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // Control store: when the condition holds the step counter loads the target,
   // otherwise it advances by one.
   function automatic ctrl_type microcode(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
      case (step)
         STEP_IDLE: w = '{op: OP_NONE, cond: COND_NO_REQ, target: STEP_IDLE};
         STEP_DEC_ERASE: w = '{op: OP_NONE, cond: COND_IS_ERASE, target: STEP_ERASE};
         STEP_DEC_KILL: w = '{op: OP_NONE, cond: COND_IS_KILL, target: STEP_CLEAR};
         STEP_DEC_WERASE: w = '{op: OP_NONE, cond: COND_IS_WERASE, target: STEP_WE_TEST};
         STEP_DEC_LF: w = '{op: OP_NONE, cond: COND_IS_LF, target: STEP_NL_CR};
         STEP_STORE: w = '{op: OP_STORE_IN, cond: COND_NEVER, target: STEP_IDLE};
         STEP_LIMIT: w = '{op: OP_NONE, cond: COND_LE_LIMIT, target: STEP_IDLE};
         STEP_FL_READ: w = '{op: OP_READ_PTR, cond: COND_NEVER, target: STEP_IDLE};
         STEP_FL_WAIT: w = '{op: OP_NONE, cond: COND_OUT_BUSY, target: STEP_FL_WAIT};
         STEP_FL_LOAD: w = '{op: OP_LOAD_OUT, cond: COND_MORE, target: STEP_FL_READ};
         STEP_CLEAR: w = '{op: OP_CLEAR, cond: COND_ALWAYS, target: STEP_IDLE};
         STEP_NL_CR: w = '{op: OP_STORE_CR, cond: COND_NEVER, target: STEP_IDLE};
         STEP_NL_MODE: w = '{op: OP_NONE, cond: COND_CR_ONLY, target: STEP_FL_READ};
         STEP_NL_LF: w = '{op: OP_STORE_LF, cond: COND_ALWAYS, target: STEP_FL_READ};
         STEP_ERASE: w = '{op: OP_DEC, cond: COND_ALWAYS, target: STEP_IDLE};
         STEP_WE_TEST: w = '{op: OP_NONE, cond: COND_COUNT_ZERO, target: STEP_IDLE};
         STEP_WE_READ: w = '{op: OP_READ_LAST, cond: COND_NEVER, target: STEP_IDLE};
         STEP_WE_CHECK: w = '{op: OP_NONE, cond: COND_RD_SPACE, target: STEP_IDLE};
         STEP_WE_DROP: w = '{op: OP_DEC, cond: COND_ALWAYS, target: STEP_WE_TEST};
         default: w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### design/leb_channels.sv
// Input channel: one text byte per request.
interface leb_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

// Result channel: one byte of a flushed line per request.
interface leb_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_byte;
   logic run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

### design/leb_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read register holds its value between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/line_edit_buffer.sv
// Channel  Dir  Payload               Handshake
// req      in   in_byte[7:0]          valid/ready, taken when both high
// rsp      out  out_byte[7:0],        valid/ready, taken when both high
//               run_last
// csr      in   5 registers, 32 bit   APB-style, pready tied high
//
// Each request holds off the next one until its edit is done. Word erase drops bytes
// one at a time until the line is empty or the last byte is a space. A newline stores
// CR and, unless cr_only is set, LF, then flushes; a flush reads each byte through the
// registered read of the line store, then clears the line. Reset is synchronous and
// clears the step counter, fill count and registers. A stalled result holds the flush
// loop; the next request is taken while the last result of a run still waits.
module line_edit_buffer (
   input  logic                              clock,
   input  logic                              reset,
   leb_req_if.sink                           req_chan,
   leb_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [leb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [leb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [leb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CW = leb_pkg::COUNT_W;
   localparam int AW = leb_pkg::ADDR_W;

   logic [leb_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [7:0] byte_ff, byte_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;
   logic [7:0] erase_ff, erase_in;
   logic [7:0] kill_ff, kill_in;
   logic [7:0] werase_ff, werase_in;
   logic cr_only_ff, cr_only_in;
   logic [5:0] limit_ff, limit_in;

   leb_pkg::ctrl_type ctrl;
   leb_pkg::reg_index_type csr_index;
   logic req_accept;
   logic csr_write;
   logic cond_true;
   logic [5:0] eff_limit;
   logic [CW-1:0] ptr_plus1;
   logic [CW-1:0] count_minus1;
   logic is_last;
   logic has_room;
   logic store_op;
   logic wr_en;
   logic [7:0] wr_data;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0] rd_data;

   // Line store.
   leb_ram #(
      .WIDTH(8),
      .DEPTH(leb_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshakes.
   assign ctrl = leb_pkg::microcode(step_ff);
   assign req_chan.ready = (step_ff == leb_pkg::STEP_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.run_last = rsp_last_ff;

   // Register port decode.
   assign csr_index = leb_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         leb_pkg::REG_ERASE: csr_prdata = {24'd0, erase_ff};
         leb_pkg::REG_KILL: csr_prdata = {24'd0, kill_ff};
         leb_pkg::REG_WERASE: csr_prdata = {24'd0, werase_ff};
         leb_pkg::REG_CR_ONLY: csr_prdata = {31'd0, cr_only_ff};
         leb_pkg::REG_LIMIT: csr_prdata = {26'd0, limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_comb begin
      erase_in = erase_ff;
      kill_in = kill_ff;
      werase_in = werase_ff;
      cr_only_in = cr_only_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index)
            leb_pkg::REG_ERASE: erase_in = csr_pwdata[7:0];
            leb_pkg::REG_KILL: kill_in = csr_pwdata[7:0];
            leb_pkg::REG_WERASE: werase_in = csr_pwdata[7:0];
            leb_pkg::REG_CR_ONLY: cr_only_in = csr_pwdata[0];
            leb_pkg::REG_LIMIT: limit_in = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   // Flush limit clamped to the range the store can hold.
   always_comb begin
      if (limit_ff == 6'd0) begin
         eff_limit = 6'd1;
      end else if (limit_ff > 6'(leb_pkg::TOP_LIMIT)) begin
         eff_limit = 6'(leb_pkg::TOP_LIMIT);
      end else begin
         eff_limit = limit_ff;
      end
   end

   assign ptr_plus1 = ptr_ff + CW'(1);
   assign count_minus1 = count_ff - CW'(1);
   assign is_last = (ptr_plus1 == count_ff);
   assign has_room = (count_ff < CW'(leb_pkg::LINE_DEPTH));

   // Jump condition select.
   always_comb begin
      case (ctrl.cond)
         leb_pkg::COND_NEVER: cond_true = 1'b0;
         leb_pkg::COND_ALWAYS: cond_true = 1'b1;
         leb_pkg::COND_NO_REQ: cond_true = !req_chan.valid;
         leb_pkg::COND_IS_ERASE: cond_true = (byte_ff == erase_ff);
         leb_pkg::COND_IS_KILL: cond_true = (byte_ff == kill_ff);
         leb_pkg::COND_IS_WERASE: cond_true = (byte_ff == werase_ff);
         leb_pkg::COND_IS_LF: cond_true = (byte_ff == leb_pkg::BYTE_LF);
         leb_pkg::COND_LE_LIMIT: cond_true = (count_ff <= {1'b0, eff_limit});
         leb_pkg::COND_OUT_BUSY: cond_true = rsp_valid_ff && !rsp_chan.ready;
         leb_pkg::COND_MORE: cond_true = !is_last;
         leb_pkg::COND_CR_ONLY: cond_true = cr_only_ff;
         leb_pkg::COND_COUNT_ZERO: cond_true = (count_ff == '0);
         leb_pkg::COND_RD_SPACE: cond_true = (rd_data == leb_pkg::BYTE_SPACE);
         default: cond_true = 1'b0;
      endcase
   end

   assign step_in = cond_true ? ctrl.target : step_ff + leb_pkg::STEP_W'(1);

   // Store port: a byte is dropped when the line is full, and the count holds.
   assign store_op = (ctrl.op == leb_pkg::OP_STORE_IN) ||
                     (ctrl.op == leb_pkg::OP_STORE_CR) ||
                     (ctrl.op == leb_pkg::OP_STORE_LF);
   assign wr_en = store_op && has_room;

   always_comb begin
      case (ctrl.op)
         leb_pkg::OP_STORE_CR: wr_data = leb_pkg::BYTE_CR;
         leb_pkg::OP_STORE_LF: wr_data = leb_pkg::BYTE_LF;
         default: wr_data = byte_ff;
      endcase
   end

   assign rd_en = (ctrl.op == leb_pkg::OP_READ_PTR) || (ctrl.op == leb_pkg::OP_READ_LAST);
   assign rd_addr = (ctrl.op == leb_pkg::OP_READ_LAST) ? count_minus1[AW-1:0] : ptr_ff[AW-1:0];

   // Datapath driven by the control word.
   always_comb begin
      count_in = count_ff;
      ptr_in = ptr_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      byte_in = req_accept ? req_chan.in_byte : byte_ff;
      case (ctrl.op)
         leb_pkg::OP_STORE_IN,
         leb_pkg::OP_STORE_CR,
         leb_pkg::OP_STORE_LF: begin
            if (has_room) begin
               count_in = count_ff + CW'(1);
            end
         end
         leb_pkg::OP_DEC: begin
            if (count_ff != '0) begin
               count_in = count_minus1;
            end
         end
         leb_pkg::OP_CLEAR: begin
            count_in = '0;
            ptr_in = '0;
         end
         leb_pkg::OP_LOAD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in = rd_data;
            rsp_last_in = is_last;
            ptr_in = ptr_plus1;
         end
         default: ;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= leb_pkg::STEP_IDLE;
         count_ff <= '0;
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         erase_ff <= leb_pkg::ERASE_RESET;
         kill_ff <= leb_pkg::KILL_RESET;
         werase_ff <= leb_pkg::WERASE_RESET;
         cr_only_ff <= leb_pkg::CR_ONLY_RESET;
         limit_ff <= leb_pkg::LIMIT_RESET;
      end else begin
         step_ff <= step_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         erase_ff <= erase_in;
         kill_ff <= kill_in;
         werase_ff <= werase_in;
         cr_only_ff <= cr_only_in;
         limit_ff <= limit_in;
      end
      byte_ff <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### design/leb_checker.sv
`include "line_edit_buffer_defines.svh"

// Port-level checks on the line edit buffer.
module leb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       csr_pready
);

   logic req_fire;
   logic rsp_stall;
   logic [8:0] rsp_payload;

   assign req_fire = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_byte, rsp_run_last};

   // A stalled result keeps its payload.
   `LEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // The block decodes a request before it takes another one.
   `LEB_ASSERT_NEXT(a_req_busy, clock, reset, req_fire, !req_ready)

   // A newly accepted request never has a result show up in the next cycle.
   `LEB_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_fire, !$rose(rsp_valid))

   // The register port never inserts wait states.
   `LEB_ASSERT_ALWAYS(a_pready_high, clock, reset, csr_pready)

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_run_last (rsp_chan.run_last),
   .csr_pready   (csr_pready)
);

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import leb_pkg::*;

   // Quiet cycles before a register write, long enough for a word erase over a full line.
   localparam int SETTLE_CYCLES = 300;
   // Cycles without any handshake before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int DIRECTED_ROWS = 35;

   typedef enum logic {ROW_KEY, ROW_REG} row_kind_type;

   // One row of the directed table: either a received byte or a register write.
   // A byte row with typed_count of -1 is checked against the line model only.
   typedef struct {
      row_kind_type kind;
      reg_index_type reg_sel;
      logic [31:0] value;
      int typed_count;
      logic [7:0] typed_first;
      logic [7:0] typed_second;
   } edit_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic run_last;
   } line_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   leb_req_if req_bus ();
   leb_rsp_if rsp_bus ();

   line_edit_buffer u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Mirror of the registers and the line held by the block.
   logic [7:0] cfg_erase;
   logic [7:0] cfg_kill;
   logic [7:0] cfg_werase;
   logic cfg_cr_only;
   logic [5:0] cfg_limit;
   logic [7:0] line_mem [LINE_DEPTH];
   int line_fill;

   line_byte_type flushed_run [$];
   line_byte_type pending_line [$];
   edit_row_type directed_rows [DIRECTED_ROWS];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;
   bit reg_burst;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic void keep_line_byte(input logic [7:0] b);
      if (line_fill < LINE_DEPTH) begin
         line_mem[line_fill] = b;
         line_fill++;
      end
   endfunction

   // Applies one received byte to the mirrored line; a flushed run lands in flushed_run.
   function automatic void edit_line(input logic [7:0] b);
      int lim;
      bit newline;
      newline = 1'b0;
      flushed_run.delete();
      lim = cfg_limit;
      if (lim < 1) begin
         lim = 1;
      end
      if (lim > TOP_LIMIT) begin
         lim = TOP_LIMIT;
      end
      if (b == cfg_erase) begin
         if (line_fill > 0) begin
            line_fill--;
         end
      end else if (b == cfg_kill) begin
         line_fill = 0;
      end else if (b == cfg_werase) begin
         while (line_fill > 0 && line_mem[line_fill-1] != BYTE_SPACE) begin
            line_fill--;
         end
      end else begin
         if (b == BYTE_LF) begin
            newline = 1'b1;
            keep_line_byte(BYTE_CR);
            if (!cfg_cr_only) begin
               keep_line_byte(BYTE_LF);
            end
         end else begin
            keep_line_byte(b);
         end
         if (newline || line_fill > lim) begin
            for (int k = 0; k < line_fill; k++) begin
               flushed_run.push_back('{out_byte: line_mem[k], run_last: (k == line_fill - 1)});
            end
            line_fill = 0;
         end
      end
   endfunction

   function automatic edit_row_type key_row(input logic [7:0] b, input int typed_count,
                                            input logic [7:0] first = 8'h00,
                                            input logic [7:0] second = 8'h00);
      return '{kind: ROW_KEY, reg_sel: REG_ERASE, value: {24'h0, b},
               typed_count: typed_count, typed_first: first, typed_second: second};
   endfunction

   function automatic edit_row_type reg_row(input reg_index_type sel, input logic [31:0] v);
      return '{kind: ROW_REG, reg_sel: sel, value: v,
               typed_count: 0, typed_first: 8'h00, typed_second: 8'h00};
   endfunction

   // Sends one byte, then records the bytes it should flush.
   task automatic send_byte(input logic [7:0] b, input int typed_count,
                            input logic [7:0] first, input logic [7:0] second);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      edit_line(b);
      if (typed_count < 0) begin
         foreach (flushed_run[i]) begin
            pending_line.push_back(flushed_run[i]);
         end
      end else begin
         if (typed_count > 0) begin
            pending_line.push_back('{out_byte: first, run_last: (typed_count == 1)});
         end
         if (typed_count > 1) begin
            pending_line.push_back('{out_byte: second, run_last: 1'b1});
         end
      end
      @(negedge clock);
   endtask

   // Waits until every flushed byte has come and any edit still running is done.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_line.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write: a setup phase, then an access phase.
   task automatic write_reg(input reg_index_type sel, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(sel) << 2;
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      case (sel)
         REG_ERASE: cfg_erase = v[7:0];
         REG_KILL: cfg_kill = v[7:0];
         REG_WERASE: cfg_werase = v[7:0];
         REG_CR_ONLY: cfg_cr_only = v[0];
         REG_LIMIT: cfg_limit = v[5:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic end_writes();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Register settings of one random phase, from the reset values to the extremes.
   task automatic configure_phase(input int phase);
      logic [7:0] code;
      code = 8'($urandom_range(0, 255));
      case (phase)
         0: begin
            write_reg(REG_ERASE, {24'h0, ERASE_RESET});
            write_reg(REG_KILL, {24'h0, KILL_RESET});
            write_reg(REG_WERASE, {24'h0, WERASE_RESET});
            write_reg(REG_CR_ONLY, 32'h0);
            write_reg(REG_LIMIT, 32'd61);
         end
         1: begin
            write_reg(REG_ERASE, 32'h08);
            write_reg(REG_KILL, 32'h18);
            write_reg(REG_WERASE, 32'h17);
            write_reg(REG_CR_ONLY, 32'h1);
            write_reg(REG_LIMIT, 32'h1);
         end
         2: begin
            write_reg(REG_ERASE, $urandom());
            write_reg(REG_KILL, $urandom());
            write_reg(REG_WERASE, $urandom());
            write_reg(REG_CR_ONLY, $urandom());
            write_reg(REG_LIMIT, $urandom_range(2, 20));
         end
         3: begin
            write_reg(REG_ERASE, 32'hFFFF_FF00);
            write_reg(REG_KILL, 32'h0000_00FF);
            write_reg(REG_WERASE, {24'h0, BYTE_SPACE});
            write_reg(REG_CR_ONLY, 32'hFFFF_FFFE);
            write_reg(REG_LIMIT, 32'hFFFF_FFFF);
         end
         4: begin
            write_reg(REG_ERASE, $urandom());
            write_reg(REG_KILL, $urandom());
            write_reg(REG_WERASE, $urandom());
            write_reg(REG_CR_ONLY, $urandom());
            write_reg(REG_LIMIT, 32'h0);
         end
         default: begin
            // All three edit codes equal, so only the erase check ever fires.
            write_reg(REG_ERASE, {24'h0, code});
            write_reg(REG_KILL, {24'h0, code});
            write_reg(REG_WERASE, {24'h0, code});
            write_reg(REG_CR_ONLY, $urandom());
            write_reg(REG_LIMIT, $urandom_range(0, 63));
         end
      endcase
      end_writes();
   endtask

   // Mostly text with spaces, edit codes and newlines; with small edit and newline shares the rest is any byte.
   function automatic logic [7:0] pick_byte(input int edit_pct, input int lf_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < edit_pct) begin
         return cfg_erase;
      end
      r -= edit_pct;
      if (r < edit_pct / 2) begin
         return cfg_kill;
      end
      r -= edit_pct / 2;
      if (r < edit_pct) begin
         return cfg_werase;
      end
      r -= edit_pct;
      if (r < lf_pct) begin
         return BYTE_LF;
      end
      r -= lf_pct;
      if (r < 12) begin
         return BYTE_SPACE;
      end
      if (r < 70) begin
         return 8'($urandom_range(8'h21, 8'h7E));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Result side stalls at random, except during the calm stretch.
   always @(negedge clock) begin
      rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
   end

   // Each flushed byte is compared with the oldest expected one.
   always @(posedge clock) begin
      line_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_line.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h", rsp_bus.out_byte));
         end else begin
            want = pending_line.pop_front();
            if (rsp_bus.out_byte !== want.out_byte) begin
               report_mismatch($sformatf("out_byte %h, expected %h",
                                         rsp_bus.out_byte, want.out_byte));
            end
            if (rsp_bus.run_last !== want.run_last) begin
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_bus.run_last, want.run_last));
            end
         end
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_erase = ERASE_RESET;
      cfg_kill = KILL_RESET;
      cfg_werase = WERASE_RESET;
      cfg_cr_only = CR_ONLY_RESET;
      cfg_limit = LIMIT_RESET;
      line_fill = 0;
      reg_burst = 1'b0;

      // Directed table: reset values, empty-buffer edits, word erase at a space,
      // newline modes, limit extremes and equal edit codes.
      directed_rows = '{
         key_row(BYTE_LF, 2, BYTE_CR, BYTE_LF),
         key_row(ERASE_RESET, 0),
         key_row(WERASE_RESET, 0),
         key_row(8'h00, 0),
         key_row(8'hFF, 0),
         key_row(BYTE_SPACE, 0),
         key_row(8'h41, 0),
         key_row(WERASE_RESET, 0),
         key_row(WERASE_RESET, 0),
         key_row(ERASE_RESET, 0),
         key_row(BYTE_LF, -1),
         key_row(8'h78, 0),
         key_row(KILL_RESET, 0),
         key_row(BYTE_LF, 2, BYTE_CR, BYTE_LF),
         reg_row(REG_CR_ONLY, 32'h1),
         key_row(BYTE_LF, 1, BYTE_CR),
         reg_row(REG_LIMIT, 32'h0),
         key_row(8'h55, 0),
         key_row(8'hAA, -1),
         reg_row(REG_LIMIT, 32'hFFFF_FFFF),
         reg_row(REG_ERASE, {24'h0, BYTE_LF}),
         reg_row(REG_KILL, {24'h0, BYTE_LF}),
         reg_row(REG_WERASE, {24'h0, BYTE_LF}),
         key_row(8'h42, 0),
         key_row(BYTE_LF, 0),
         reg_row(REG_ERASE, {24'h0, ERASE_RESET}),
         key_row(BYTE_SPACE, 0),
         key_row(8'h44, 0),
         key_row(BYTE_LF, 0),
         reg_row(REG_KILL, {24'h0, KILL_RESET}),
         key_row(BYTE_SPACE, 0),
         key_row(8'h44, 0),
         key_row(BYTE_LF, 0),
         reg_row(REG_WERASE, {24'h0, WERASE_RESET}),
         key_row(BYTE_LF, -1)
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part; back-to-back register rows form one burst of writes.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            if (!reg_burst) begin
               settle();
            end
            write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            reg_burst = 1'b1;
         end else begin
            if (reg_burst) begin
               end_writes();
            end
            reg_burst = 1'b0;
            send_byte(directed_rows[i].value[7:0], directed_rows[i].typed_count,
                      directed_rows[i].typed_first, directed_rows[i].typed_second);
         end
      end

      // Random phases; the first one uses few edits and newlines so lines reach the limit.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         configure_phase(phase);
         calm = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_byte(phase == 0 ? pick_byte(2, 1) : pick_byte(8, 10), -1, 8'h00, 8'h00);
         end
         calm = 1'b0;
      end

      // Drain what is still expected, then watch for stray output.
      req_bus.valid <= 1'b0;
      while (pending_line.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### line_edit_buffer.f
+incdir+design
design/leb_pkg.sv
design/leb_channels.sv
design/leb_ram.sv
design/line_edit_buffer.sv
design/leb_checker.sv
sim/testbench.sv
